/* src/tlpw_pkg.sv */
// Package for the two-level page walk core: request/command types, codes and sizing constants.
// No dependencies.
`default_nettype none
package tlpw_pkg;
  localparam int TableEntriesDef = 64;
  localparam int TlbSizeDef      = 8;
  localparam int FrameBitsDef    = 11;
  localparam int VaBits          = 32;
  localparam int PhysBits        = 28;
  localparam int OffBits         = 12;
  localparam int OutFrameBits    = 11;
  localparam int SelBits         = 6;
  localparam int ValBits         = 11;
  localparam int PnBits          = 10;
  localparam int QDepth          = 2;

  typedef enum logic [1:0] {
    FUNC_XLATE = 2'd0,
    FUNC_WR_L1 = 2'd1,
    FUNC_WR_L2 = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CMD_XLATE = 2'd0,
    CMD_FAULT = 2'd1,
    CMD_WR_L1 = 2'd2,
    CMD_WR_L2 = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PnBits-1:0] p1;
    logic [PnBits-1:0] p2;
    logic [OffBits-1:0] off;
    logic [SelBits-1:0] tsel;
    logic [SelBits-1:0] esel;
    logic [ValBits-1:0] val;
  } cmd_beat_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_L1,
    ST_L2,
    ST_OUT
  } bstate_t;
endpackage
`default_nettype wire

/* src/two_level_page_walk_with_tlb_core.sv */
// Two-level page walk with per-table TLB sets.
// A translation passes the queue, the first-level read, the TLB row plus second-level read
// and the result register; a fault beat goes from the queue straight to the result.
// The single walk engine takes a new beat only when idle, so it finishes each translation or
// fault before the next; a table write is done as it is taken. A stalled result holds the
// engine, and the queue then fills. Reset clears the queue and every TLB set before any walk.
`default_nettype none
module two_level_page_walk_with_tlb_core #(
  parameter int TABLE_ENTRIES = tlpw_pkg::TableEntriesDef,
  parameter int TLB_SIZE      = tlpw_pkg::TlbSizeDef,
  parameter int FRAME_BITS    = tlpw_pkg::FrameBitsDef
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            func,
  input  wire logic [tlpw_pkg::VaBits-1:0]           virt_addr,
  input  wire logic [tlpw_pkg::SelBits-1:0]          table_sel,
  input  wire logic [tlpw_pkg::SelBits-1:0]          entry_sel,
  input  wire logic [tlpw_pkg::ValBits-1:0]          entry_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [tlpw_pkg::PhysBits-1:0]              phys_addr,
  output logic [tlpw_pkg::OutFrameBits-1:0]          frame_number,
  output logic                                       tlb_hit,
  output logic                                       fault
);
  // The front end classifies each beat and parks those it keeps in a two-entry queue, so the
  // input side keeps moving while the back end walks tables or waits on a stalled result.
  logic                q_valid, q_pop;
  tlpw_pkg::cmd_beat_t q_beat;

  tlpw_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall), .func(func),
    .virt_addr(virt_addr), .table_sel(table_sel), .entry_sel(entry_sel),
    .entry_value(entry_value), .q_valid(q_valid), .q_beat(q_beat), .q_pop(q_pop)
  );

  // The back end owns all tables and runs table writes and walks in queue order,
  // which keeps write-then-translate sequences coherent.
  tlpw_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .TLB_SIZE(TLB_SIZE), .FRAME_BITS(FRAME_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_beat(q_beat), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .phys_addr(phys_addr),
    .frame_number(frame_number), .tlb_hit(tlb_hit), .fault(fault)
  );
endmodule
`default_nettype wire

/* src/tlpw_front.sv */
// Front end: accepts request beats, classifies them and range-checks indexes.
// Depends on tlpw_pkg.
`default_nettype none
module tlpw_front #(
  parameter int TABLE_ENTRIES = tlpw_pkg::TableEntriesDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         valid,
  output logic                              stall,
  input  wire logic [1:0]                   func,
  input  wire logic [tlpw_pkg::VaBits-1:0]  virt_addr,
  input  wire logic [tlpw_pkg::SelBits-1:0] table_sel,
  input  wire logic [tlpw_pkg::SelBits-1:0] entry_sel,
  input  wire logic [tlpw_pkg::ValBits-1:0] entry_value,
  output logic                              q_valid,
  output tlpw_pkg::cmd_beat_t               q_beat,
  input  wire logic                         q_pop
);
  localparam int QW = $clog2(tlpw_pkg::QDepth);
  tlpw_pkg::cmd_beat_t qmem [tlpw_pkg::QDepth];
  logic [QW-1:0] rd_ptr, wr_ptr;
  logic [QW:0]   count;
  tlpw_pkg::cmd_beat_t beat;
  logic push, keep, p1_ok, p2_ok, ts_ok, es_ok;

  assign stall = (count == (QW+1)'(tlpw_pkg::QDepth));
  assign p1_ok = {22'd0, virt_addr[31:22]} < TABLE_ENTRIES;
  assign p2_ok = {22'd0, virt_addr[21:12]} < TABLE_ENTRIES;
  assign ts_ok = {26'd0, table_sel} < TABLE_ENTRIES;
  assign es_ok = {26'd0, entry_sel} < TABLE_ENTRIES;

  always_comb begin
    beat      = '0;
    beat.p1   = virt_addr[31:22];
    beat.p2   = virt_addr[21:12];
    beat.off  = virt_addr[11:0];
    beat.tsel = table_sel;
    beat.esel = entry_sel;
    beat.val  = entry_value;
    keep      = 1'b0;
    unique case (tlpw_pkg::func_t'(func))
      tlpw_pkg::FUNC_XLATE: begin
        keep = 1'b1;
        beat.cmd = (p1_ok && p2_ok) ? tlpw_pkg::CMD_XLATE : tlpw_pkg::CMD_FAULT;
      end
      tlpw_pkg::FUNC_WR_L1: begin
        keep = ts_ok;
        beat.cmd = tlpw_pkg::CMD_WR_L1;
      end
      tlpw_pkg::FUNC_WR_L2: begin
        keep = ts_ok && es_ok;
        beat.cmd = tlpw_pkg::CMD_WR_L2;
      end
      default: begin
        keep = 1'b0;
        beat.cmd = tlpw_pkg::CMD_FAULT;
      end
    endcase
  end

  assign push    = valid && !stall && keep;
  assign q_valid = (count != '0);
  assign q_beat  = qmem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QW+1)'(push) - (QW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

/* src/tlpw_back.sv */
// Back end: table memories, per-table TLB sets, page walk and result register.
// Depends on tlpw_pkg.
`default_nettype none
module tlpw_back #(
  parameter int TABLE_ENTRIES = tlpw_pkg::TableEntriesDef,
  parameter int TLB_SIZE      = tlpw_pkg::TlbSizeDef,
  parameter int FRAME_BITS    = tlpw_pkg::FrameBitsDef
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire tlpw_pkg::cmd_beat_t               q_beat,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [tlpw_pkg::PhysBits-1:0]          phys_addr,
  output logic [tlpw_pkg::OutFrameBits-1:0]      frame_number,
  output logic                                   tlb_hit,
  output logic                                   fault
);
  localparam int TB   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int WB   = (TLB_SIZE > 1) ? $clog2(TLB_SIZE) : 1;
  localparam int USE  = TLB_SIZE - 1;
  localparam int SETS = TABLE_ENTRIES;
  localparam int PB   = TB;
  localparam int EW   = PB + FRAME_BITS;
  localparam int RW   = TLB_SIZE * EW;
  localparam int MW   = RW + TLB_SIZE + WB;

  // Storage.
  logic [tlpw_pkg::SelBits-1:0] l1_mem [TABLE_ENTRIES];
  logic [FRAME_BITS-1:0]        l2_mem [2**(2*TB)];
  // One word per table: page and frame of every way, the way valid bits above
  // them and the round-robin fill pointer on top.
  logic [MW-1:0]                tlb_mem [SETS];

  tlpw_pkg::bstate_t state, state_next;
  tlpw_pkg::cmd_beat_t cur;
  logic [tlpw_pkg::SelBits-1:0] l1_rd;
  logic [FRAME_BITS-1:0]        l2_rd;
  logic [MW-1:0] row_rd, row_new, tlb_wdata;
  logic [TLB_SIZE-1:0] vld_rd;
  logic [WB-1:0] fp_rd;
  logic [TB-1:0] tbl, tlb_waddr, clr_idx;
  logic tbl_ok, hit;
  logic [FRAME_BITS-1:0] hit_frame, frame;
  logic [WB-1:0] ptr;
  logic take, tlb_wr, tlb_we;
  logic [tlpw_pkg::PhysBits-1:0]     o_phys;
  logic [tlpw_pkg::OutFrameBits-1:0] o_frame;
  logic o_hit, o_fault;

  assign take  = q_valid && (state == tlpw_pkg::ST_IDLE);
  assign q_pop = take;
  assign tbl   = l1_rd[TB-1:0];
  assign tbl_ok = {26'd0, l1_rd} < TABLE_ENTRIES;

  always_ff @(posedge clk) begin
    if (take) begin
      cur   <= q_beat;
      l1_rd <= l1_mem[q_beat.p1[TB-1:0]];
    end
    if (take && q_beat.cmd == tlpw_pkg::CMD_WR_L1) begin
      l1_mem[q_beat.tsel[TB-1:0]] <= q_beat.val[tlpw_pkg::SelBits-1:0];
    end
    if (take && q_beat.cmd == tlpw_pkg::CMD_WR_L2) begin
      l2_mem[{q_beat.tsel[TB-1:0], q_beat.esel[TB-1:0]}] <= q_beat.val[FRAME_BITS-1:0];
    end
  end

  // In ST_L1 the TLB row and table entry are read with the first-level result.
  // After reset the rows are cleared one per cycle before any walk starts.
  assign tlb_wr    = (state == tlpw_pkg::ST_L2) && !hit;
  assign tlb_we    = tlb_wr || (state == tlpw_pkg::ST_CLR);
  assign tlb_waddr = (state == tlpw_pkg::ST_CLR) ? clr_idx : tbl;
  assign tlb_wdata = (state == tlpw_pkg::ST_CLR) ? '0 : row_new;

  always_ff @(posedge clk) begin
    l2_rd  <= l2_mem[{tbl, cur.p2[TB-1:0]}];
    row_rd <= tlb_mem[tbl];
    if (tlb_we) begin
      tlb_mem[tlb_waddr] <= tlb_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == tlpw_pkg::ST_CLR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_comb begin
    vld_rd = row_rd[RW +: TLB_SIZE];
    fp_rd  = row_rd[RW+TLB_SIZE +: WB];
    hit = 1'b0;
    hit_frame = '0;
    for (int i = 0; i < USE; i++) begin
      if (vld_rd[i] && row_rd[i*EW +: PB] == cur.p2[PB-1:0]) begin
        hit = 1'b1;
        hit_frame = row_rd[i*EW+PB +: FRAME_BITS];
      end
    end
    ptr = (32'(fp_rd) >= USE) ? '0 : fp_rd;
    frame = hit ? hit_frame : l2_rd;
    row_new = row_rd;
    row_new[32'(ptr)*EW +: EW] = {l2_rd, cur.p2[PB-1:0]};
    row_new[RW + 32'(ptr)] = 1'b1;
    row_new[RW+TLB_SIZE +: WB] = WB'(32'(ptr) + 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlpw_pkg::ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tlpw_pkg::ST_CLR: begin
        if (32'(clr_idx) == SETS - 1) begin
          state_next = tlpw_pkg::ST_IDLE;
        end
      end
      tlpw_pkg::ST_IDLE: begin
        if (take) begin
          unique case (q_beat.cmd)
            tlpw_pkg::CMD_XLATE: state_next = tlpw_pkg::ST_L1;
            tlpw_pkg::CMD_FAULT: state_next = tlpw_pkg::ST_OUT;
            default:             state_next = tlpw_pkg::ST_IDLE;
          endcase
        end
      end
      tlpw_pkg::ST_L1: state_next = tbl_ok ? tlpw_pkg::ST_L2 : tlpw_pkg::ST_OUT;
      tlpw_pkg::ST_L2: state_next = tlpw_pkg::ST_OUT;
      tlpw_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = tlpw_pkg::ST_IDLE;
        end
      end
      default: state_next = tlpw_pkg::ST_IDLE;
    endcase
  end

  // Result register; the fault flag is set when a beat is taken and cleared when ST_L2 loads a translation.
  always_ff @(posedge clk) begin
    if (take) begin
      o_phys  <= '0;
      o_frame <= '0;
      o_hit   <= 1'b0;
      o_fault <= 1'b1;
    end else if (state == tlpw_pkg::ST_L2) begin
      o_phys  <= tlpw_pkg::PhysBits'({frame, cur.off});
      o_frame <= tlpw_pkg::OutFrameBits'(frame);
      o_hit   <= hit;
      o_fault <= 1'b0;
    end
  end

  assign out_valid    = (state == tlpw_pkg::ST_OUT);
  assign phys_addr    = o_phys;
  assign frame_number = o_frame;
  assign tlb_hit      = o_hit;
  assign fault        = o_fault;
endmodule
`default_nettype wire

/* tb/tlpw_walk_checker.sv */
// Checker for the two-level page walk core: watches both channels, predicts each result.
// Depends on tlpw_pkg for the function codes and field widths.
`timescale 1ns / 100ps
module tlpw_walk_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [1:0]                           func,
  input  logic [tlpw_pkg::VaBits-1:0]          virt_addr,
  input  logic [tlpw_pkg::SelBits-1:0]         table_sel,
  input  logic [tlpw_pkg::SelBits-1:0]         entry_sel,
  input  logic [tlpw_pkg::ValBits-1:0]         entry_value,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [tlpw_pkg::PhysBits-1:0]        phys_addr,
  input  logic [tlpw_pkg::OutFrameBits-1:0]    frame_number,
  input  logic                                 tlb_hit,
  input  logic                                 fault,
  output int                                   errors,
  output int                                   pending
);
  localparam int NTbl = tlpw_pkg::TableEntriesDef;
  localparam int NWay = tlpw_pkg::TlbSizeDef;
  localparam int QLen = 256;

  typedef struct packed {
    logic [tlpw_pkg::PhysBits-1:0]     phys;
    logic [tlpw_pkg::OutFrameBits-1:0] frame;
    logic                              hit;
    logic                              flt;
  } xlate_res_t;

  logic [5:0]                  dir_tbl [NTbl];
  logic [10:0]                 page_frame [NTbl*NTbl];
  logic [tlpw_pkg::PnBits-1:0] way_page [NTbl*NWay];
  logic [10:0]                 way_frame [NTbl*NWay];
  logic                        way_ok [NTbl*NWay];
  int                          rr_ptr [NTbl];
  // Expected results in order, kept as a ring.
  xlate_res_t                  awaited [QLen];
  int                          wr_cnt, rd_cnt;

  function automatic xlate_res_t walk_addr(logic [31:0] va);
    xlate_res_t r;
    logic [tlpw_pkg::PnBits-1:0] p1, p2;
    int tb, base, ptr;
    logic hit;
    logic [10:0] fr;
    p1 = va[31:22];
    p2 = va[21:12];
    r = '0;
    hit = 1'b0;
    fr = '0;
    if (p1 >= NTbl || p2 >= NTbl) begin
      r.flt = 1'b1;
      return r;
    end
    tb = dir_tbl[p1];
    base = tb * NWay;
    for (int i = 0; i < NWay - 1; i++) begin
      if (way_ok[base+i] && way_page[base+i] == p2) begin
        hit = 1'b1;
        fr = way_frame[base+i];
      end
    end
    if (!hit) begin
      fr = page_frame[tb*NTbl + p2];
      ptr = rr_ptr[tb];
      if (ptr >= NWay - 1) ptr = 0;
      way_page[base+ptr] = p2;
      way_frame[base+ptr] = fr;
      way_ok[base+ptr] = 1'b1;
      rr_ptr[tb] = ptr + 1;
    end
    r.phys = {5'd0, fr, va[11:0]};
    r.frame = fr;
    r.hit = hit;
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    wr_cnt = 0;
    rd_cnt = 0;
    for (int i = 0; i < NTbl*NWay; i++) way_ok[i] = 1'b0;
    for (int i = 0; i < NTbl; i++) rr_ptr[i] = 0;
  end

  always @(posedge clk) begin
    xlate_res_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (wr_cnt == rd_cnt) begin
          $error("result beat with nothing expected: phys_addr=%h", phys_addr);
          errors++;
        end else begin
          want = awaited[rd_cnt % QLen];
          rd_cnt++;
          if (phys_addr !== want.phys) begin
            $error("phys_addr: expected %h, got %h", want.phys, phys_addr);
            errors++;
          end
          if (frame_number !== want.frame) begin
            $error("frame_number: expected %h, got %h", want.frame, frame_number);
            errors++;
          end
          if (tlb_hit !== want.hit) begin
            $error("tlb_hit: expected %b, got %b", want.hit, tlb_hit);
            errors++;
          end
          if (fault !== want.flt) begin
            $error("fault: expected %b, got %b", want.flt, fault);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (func)
          tlpw_pkg::FUNC_XLATE: begin
            awaited[wr_cnt % QLen] = walk_addr(virt_addr);
            wr_cnt++;
          end
          tlpw_pkg::FUNC_WR_L1: dir_tbl[table_sel] = entry_value[5:0];
          tlpw_pkg::FUNC_WR_L2: page_frame[table_sel*NTbl + entry_sel] = entry_value;
          default: ;
        endcase
      end
      pending = wr_cnt - rd_cnt;
    end
  end
endmodule

/* tb/tb_two_level_page_walk_with_tlb_core.sv */
// Top of the page walk testbench: clock, reset, stimulus, receiver stalls and the verdict.
// Depends on tlpw_pkg, the core and tlpw_walk_checker.
`timescale 1ns / 100ps
module tb_two_level_page_walk_with_tlb_core;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = tlpw_pkg::FUNC_NONE;
  logic [tlpw_pkg::VaBits-1:0] virt_addr = '0;
  logic [tlpw_pkg::SelBits-1:0] table_sel = '0;
  logic [tlpw_pkg::SelBits-1:0] entry_sel = '0;
  logic [tlpw_pkg::ValBits-1:0] entry_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [tlpw_pkg::PhysBits-1:0] phys_addr;
  logic [tlpw_pkg::OutFrameBits-1:0] frame_number;
  logic tlb_hit, fault;
  int errors, pending;

  // The sender raises this to ask the receiver for one long hold-off.
  logic hold_req = 1'b0;
  // When set, the sender offers beats back to back with no gaps.
  logic burst = 1'b0;

  // Shadow of which table entries have been written, so that no translation
  // ever walks into an entry that holds no defined value.
  bit       dir_set [64];
  logic [5:0] dir_val [64];
  bit       leaf_set [64*64];

  two_level_page_walk_with_tlb_core u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .virt_addr(virt_addr), .table_sel(table_sel), .entry_sel(entry_sel),
    .entry_value(entry_value), .out_valid(out_valid), .out_stall(out_stall),
    .phys_addr(phys_addr), .frame_number(frame_number), .tlb_hit(tlb_hit), .fault(fault)
  );

  tlpw_walk_checker u_chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .virt_addr(virt_addr), .table_sel(table_sel), .entry_sel(entry_sel),
    .entry_value(entry_value), .out_valid(out_valid), .out_stall(out_stall),
    .phys_addr(phys_addr), .frame_number(frame_number), .tlb_hit(tlb_hit), .fault(fault),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat and hold it until the core takes it. Valid stays high
  // when the next beat follows with no gap, so it is assigned once per edge.
  task automatic send_beat(logic [1:0] f, logic [31:0] va, logic [5:0] ts,
                           logic [5:0] es, logic [10:0] ev);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    virt_addr <= va;
    table_sel <= ts;
    entry_sel <= es;
    entry_value <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f == tlpw_pkg::FUNC_WR_L1) begin
      dir_set[ts] = 1'b1;
      dir_val[ts] = ev[5:0];
    end else if (f == tlpw_pkg::FUNC_WR_L2) begin
      leaf_set[ts*64 + es] = 1'b1;
    end
  endtask

  task automatic send_xlate(logic [9:0] p1, logic [9:0] p2, logic [11:0] off);
    send_beat(tlpw_pkg::FUNC_XLATE, {p1, p2, off}, 6'($urandom), 6'($urandom),
              11'($urandom));
  endtask

  // One random beat. Most are well-formed translations over a small working
  // set so that TLB sets fill, hit and wrap; the missing table entries are
  // written first when a pick lands on one.
  task automatic random_beat();
    int r;
    logic [9:0] p1, p2;
    logic [31:0] va;
    r = $urandom_range(0, 99);
    p1 = 10'($urandom_range(0, 63));
    p2 = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 63)) :
                                       10'($urandom_range(0, 15));
    if (r < 3) begin
      send_beat(tlpw_pkg::FUNC_NONE, $urandom, 6'($urandom), 6'($urandom), 11'($urandom));
    end else if (r < 8) begin
      // Page number out of range in either field; upper bits fully random.
      va = $urandom;
      if ($urandom_range(0, 1)) va[31:28] = 4'($urandom_range(1, 15));
      else va[21:18] = 4'($urandom_range(1, 15));
      send_beat(tlpw_pkg::FUNC_XLATE, va, 6'($urandom), 6'($urandom), 11'($urandom));
    end else if (r < 13) begin
      send_beat(tlpw_pkg::FUNC_WR_L1, $urandom, 6'(p1), 6'($urandom),
                {5'($urandom_range(0, 31)), 6'($urandom_range(0, 7))});
    end else if (r < 22) begin
      send_beat(tlpw_pkg::FUNC_WR_L2, $urandom, 6'($urandom_range(0, 7)), 6'(p2),
                11'($urandom));
    end else if (!dir_set[p1]) begin
      send_beat(tlpw_pkg::FUNC_WR_L1, $urandom, 6'(p1), 6'($urandom),
                {5'($urandom_range(0, 31)), 6'($urandom_range(0, 7))});
    end else if (!leaf_set[dir_val[p1]*64 + p2]) begin
      send_beat(tlpw_pkg::FUNC_WR_L2, $urandom, dir_val[p1], 6'(p2), 11'($urandom));
    end else begin
      send_xlate(p1, p2, 12'($urandom));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (burst) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= (pick_gap() > 2);
      end
    end
  end

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats: tables at the edges, extreme frames and offsets,
    // miss then hit, a stale TLB entry after a table rewrite, faults on
    // both page fields, an unused function code and a full round-robin wrap.
    send_beat(tlpw_pkg::FUNC_WR_L1, 32'h0, 6'd0, 6'd0, 11'h7C5);
    send_beat(tlpw_pkg::FUNC_WR_L1, 32'hFFFF_FFFF, 6'd63, 6'd63, 11'h000);
    send_beat(tlpw_pkg::FUNC_WR_L2, 32'h0, 6'd5, 6'd0, 11'h7FF);
    send_beat(tlpw_pkg::FUNC_WR_L2, 32'h0, 6'd0, 6'd63, 11'h000);
    send_xlate(10'd0, 10'd0, 12'hFFF);
    send_xlate(10'd0, 10'd0, 12'h000);
    send_xlate(10'd63, 10'd63, 12'h000);
    send_beat(tlpw_pkg::FUNC_WR_L2, 32'h0, 6'd5, 6'd0, 11'h001);
    send_xlate(10'd0, 10'd0, 12'h5A5);
    send_beat(tlpw_pkg::FUNC_XLATE, 32'hFFFF_FFFF, 6'd0, 6'd0, 11'h0);
    send_xlate(10'd0, 10'd64, 12'h0);
    send_xlate(10'd1023, 10'd0, 12'h0);
    send_beat(tlpw_pkg::FUNC_NONE, 32'hFFFF_FFFF, 6'd63, 6'd63, 11'h7FF);
    for (int e = 1; e < 8; e++) begin
      send_beat(tlpw_pkg::FUNC_WR_L2, 32'h0, 6'd5, 6'(e), 11'(e * 3));
    end
    for (int e = 1; e < 8; e++) send_xlate(10'd0, 10'(e), 12'(e));
    send_xlate(10'd0, 10'd0, 12'h0);

    for (n = 0; n < 2000; n++) begin
      if (n % 150 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == 500) begin
        burst = 1'b1;
        hold_req <= 1'b1;
      end
      if (n == 1000) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_beat();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end
endmodule
